// ===== design/nist_pkg.sv =====
// ----------------------------------------------------------------------------
// nist_pkg: shared constants and types for the nested interval self time core
// Stack sizing, field widths and the stack control bundle.
// ----------------------------------------------------------------------------
package nist_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int TAG_BITS    = 16;
  localparam int TIME_W      = 64;
  localparam int OUT_TAG_W   = 16;
  localparam int IN_TAG_W    = 16;

  localparam int PTR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef struct packed {
    logic push;
    logic pop;
    logic wr_self;
  } stk_ctrl_t;

endpackage

// ===== design/nist_alu.sv =====
// ----------------------------------------------------------------------------
// nist_alu: shared 64-bit add/subtract unit
// Gives the sum or difference and the carry out; on a subtract the carry is
// set when a >= b.
// ----------------------------------------------------------------------------
module nist_alu
  import nist_pkg::*;
(
  input  logic [TIME_W-1:0] a_i,
  input  logic [TIME_W-1:0] b_i,
  input  logic              sub_i,
  output logic [TIME_W-1:0] res_o,
  output logic              carry_o
);

  logic [TIME_W:0] sum;

  assign sum     = {1'b0, a_i} + {1'b0, b_i ^ {TIME_W{sub_i}}} + {{TIME_W{1'b0}}, sub_i};
  assign res_o   = sum[TIME_W-1:0];
  assign carry_o = sum[TIME_W];

endmodule

// ===== design/nist_stack.sv =====
// ----------------------------------------------------------------------------
// nist_stack: stack of open intervals
// Holds start, end, self time and tag per entry and exposes the top entry.
// ----------------------------------------------------------------------------
module nist_stack
  import nist_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stk_ctrl_t           ctrl_i,
  input  logic [TIME_W-1:0]   push_start_i,
  input  logic [TIME_W-1:0]   push_end_i,
  input  logic [TIME_W-1:0]   push_self_i,
  input  logic [TAG_BITS-1:0] push_tag_i,
  input  logic [TIME_W-1:0]   wr_self_i,
  output logic [TIME_W-1:0]   top_start_o,
  output logic [TIME_W-1:0]   top_end_o,
  output logic [TIME_W-1:0]   top_self_o,
  output logic [TAG_BITS-1:0] top_tag_o,
  output logic [DEPTH_W-1:0]  depth_o
);

  logic [TIME_W-1:0]   start_mem [STACK_DEPTH];
  logic [TIME_W-1:0]   end_mem   [STACK_DEPTH];
  logic [TIME_W-1:0]   self_mem  [STACK_DEPTH];
  logic [TAG_BITS-1:0] tag_mem   [STACK_DEPTH];

  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [DEPTH_W-1:0] top_full;
  logic [PTR_W-1:0]   top_idx;
  logic [PTR_W-1:0]   push_idx;

  assign top_full = depth_q - DEPTH_W'(1);
  assign top_idx  = top_full[PTR_W-1:0];
  assign push_idx = depth_q[PTR_W-1:0];

  always_comb begin
    depth_d = depth_q;
    if (ctrl_i.push) begin
      depth_d = depth_q + DEPTH_W'(1);
    end else if (ctrl_i.pop) begin
      depth_d = depth_q - DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      start_mem[push_idx] <= push_start_i;
      end_mem[push_idx]   <= push_end_i;
      self_mem[push_idx]  <= push_self_i;
      tag_mem[push_idx]   <= push_tag_i;
    end else if (ctrl_i.wr_self) begin
      self_mem[top_idx] <= wr_self_i;
    end
  end

  assign top_start_o = start_mem[top_idx];
  assign top_end_o   = end_mem[top_idx];
  assign top_self_o  = self_mem[top_idx];
  assign top_tag_o   = tag_mem[top_idx];
  assign depth_o     = depth_q;

endmodule

// ===== design/nested_interval_self_time_core.sv =====
// ----------------------------------------------------------------------------
// nested_interval_self_time_core: self time of nested timed intervals
// Keeps a stack of open intervals and emits each finished one with its
// self time after the durations of its direct children are taken off.
// ----------------------------------------------------------------------------
// Usage: items enter on the in_* valid/ready channel, one at a time; in_ready_o
// is high only while the sequencer is idle. An add event pops every open
// interval that does not enclose it, then is emitted (zero length), pushed,
// or emitted with out_overflow_o set when the stack is full. A flush pops the
// whole stack, top first. Results leave on the out_* valid/ready channel;
// last_o marks the final result of an item.
// Timing: one 64-bit adder serves the end-time sum, the three enclosure
// compares and the self time deduction, each in a state of its own.
// A result is held in a pending register so that its last flag is known;
// while the output register is not taken, the sequencer waits at the next
// result it produces.
// Reset empties the stack and drops any result in flight; the stack storage
// itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module nested_interval_self_time_core
  import nist_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [TIME_W-1:0]    start_time_i,
  input  logic [TIME_W-1:0]    length_i,
  input  logic [TIME_W-1:0]    initial_self_time_i,
  input  logic [IN_TAG_W-1:0]  event_tag_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_TAG_W-1:0] out_tag_o,
  output logic [TIME_W-1:0]    out_self_time_o,
  output logic                 out_overflow_o,
  output logic                 last_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_END   = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_C1    = 4'd3;
  localparam logic [3:0] S_C2    = 4'd4;
  localparam logic [3:0] S_C3    = 4'd5;
  localparam logic [3:0] S_POP   = 4'd6;
  localparam logic [3:0] S_PLACE = 4'd7;
  localparam logic [3:0] S_DED   = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_q, state_d;

  logic                func_q;
  logic [TIME_W-1:0]   start_q, len_q, self_q, end_q;
  logic [TAG_BITS-1:0] tag_q;

  logic [TIME_W-1:0]   top_start, top_end, top_self;
  logic [TAG_BITS-1:0] top_tag;
  logic [DEPTH_W-1:0]  depth;
  stk_ctrl_t           stk_ctrl;
  logic [TIME_W-1:0]   wr_self;

  logic [TIME_W-1:0] alu_a, alu_b, alu_res;
  logic              alu_sub, alu_carry;

  logic                pend_valid_q;
  logic [TAG_BITS-1:0] pend_tag_q;
  logic [TIME_W-1:0]   pend_self_q;
  logic                pend_ovf_q;

  logic                 out_valid_q;
  logic [OUT_TAG_W-1:0] out_tag_q;
  logic [TIME_W-1:0]    out_self_q;
  logic                 out_ovf_q;
  logic                 out_last_q;

  logic                emit_req, emit_ok, emit_fire, fin_move, out_free;
  logic [TAG_BITS-1:0] emit_tag;
  logic [TIME_W-1:0]   emit_self;
  logic                emit_ovf;
  logic                in_fire, stack_empty, stack_full;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign stack_empty = (depth == '0);
  assign stack_full  = (depth >= DEPTH_W'(STACK_DEPTH));
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit_ok     = !pend_valid_q || out_free;
  assign emit_fire   = emit_req && emit_ok;
  assign fin_move    = (state_q == S_FIN) && pend_valid_q && out_free;

  nist_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  nist_stack u_stack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (stk_ctrl),
    .push_start_i (start_q),
    .push_end_i   (end_q),
    .push_self_i  (self_q),
    .push_tag_i   (tag_q),
    .wr_self_i    (wr_self),
    .top_start_o  (top_start),
    .top_end_o    (top_end),
    .top_self_o   (top_self),
    .top_tag_o    (top_tag),
    .depth_o      (depth)
  );

  // The deduction clamps at zero when the child is at least as long as the
  // parent's remaining self time.
  assign wr_self = alu_carry ? alu_res : '0;

  always_comb begin
    state_d   = state_q;
    alu_a     = start_q;
    alu_b     = len_q;
    alu_sub   = 1'b0;
    stk_ctrl  = '0;
    emit_req  = 1'b0;
    emit_tag  = tag_q;
    emit_self = self_q;
    emit_ovf  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (func_i == FUNC_FLUSH) ? S_CHK : S_END;
        end
      end
      S_END: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (stack_empty) begin
          state_d = (func_q == FUNC_FLUSH) ? S_FIN : S_PLACE;
        end else begin
          state_d = (func_q == FUNC_FLUSH) ? S_POP : S_C1;
        end
      end
      S_C1: begin
        alu_a   = start_q;
        alu_b   = top_start;
        alu_sub = 1'b1;
        state_d = alu_carry ? S_C2 : S_POP;
      end
      S_C2: begin
        alu_a   = top_end;
        alu_b   = end_q;
        alu_sub = 1'b1;
        state_d = alu_carry ? S_C3 : S_POP;
      end
      S_C3: begin
        alu_a   = start_q;
        alu_b   = top_end;
        alu_sub = 1'b1;
        state_d = alu_carry ? S_POP : S_PLACE;
      end
      S_POP: begin
        emit_req  = 1'b1;
        emit_tag  = top_tag;
        emit_self = top_self;
        if (emit_ok) begin
          stk_ctrl.pop = 1'b1;
          state_d      = S_CHK;
        end
      end
      S_PLACE: begin
        if (len_q == '0) begin
          emit_req = 1'b1;
          if (emit_ok) begin
            state_d = S_FIN;
          end
        end else begin
          state_d = stack_empty ? S_PUSH : S_DED;
        end
      end
      S_DED: begin
        alu_a            = top_self;
        alu_b            = len_q;
        alu_sub          = 1'b1;
        stk_ctrl.wr_self = 1'b1;
        state_d          = S_PUSH;
      end
      S_PUSH: begin
        if (stack_full) begin
          emit_req = 1'b1;
          emit_ovf = 1'b1;
          if (emit_ok) begin
            state_d = S_FIN;
          end
        end else begin
          stk_ctrl.push = 1'b1;
          state_d       = S_FIN;
        end
      end
      S_FIN: begin
        if (!pend_valid_q || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_fire) begin
        pend_valid_q <= 1'b1;
      end else if (fin_move) begin
        pend_valid_q <= 1'b0;
      end
      if ((emit_fire && pend_valid_q) || fin_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q  <= func_i;
      start_q <= start_time_i;
      len_q   <= length_i;
      self_q  <= initial_self_time_i;
      tag_q   <= TAG_BITS'(event_tag_i);
    end
    if (state_q == S_END) begin
      // The end time saturates when the sum wraps.
      end_q <= alu_carry ? '1 : alu_res;
    end
    if (emit_fire) begin
      pend_tag_q  <= emit_tag;
      pend_self_q <= emit_self;
      pend_ovf_q  <= emit_ovf;
    end
    if ((emit_fire && pend_valid_q) || fin_move) begin
      out_tag_q  <= OUT_TAG_W'(pend_tag_q);
      out_self_q <= pend_self_q;
      out_ovf_q  <= pend_ovf_q;
      out_last_q <= fin_move;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_tag_o       = out_tag_q;
  assign out_self_time_o = out_self_q;
  assign out_overflow_o  = out_ovf_q;
  assign last_o          = out_last_q;

`ifndef NO_ASSERTIONS
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_valid_q)
    else $error("held result left over while idle");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_ctrl.push |-> !stack_full)
    else $error("push on a full stack");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stk_ctrl.pop || stk_ctrl.wr_self) |-> !stack_empty)
    else $error("stack top used while empty");
`endif

endmodule

// ===== tb/tb_nested_interval_self_time_core.sv =====
// ----------------------------------------------------------------------------
// tb_nested_interval_self_time_core: testbench for the nested interval core
// Sends directed and random event streams with random gaps on both channels
// and checks every emitted interval against a built-in stack predictor.
// ----------------------------------------------------------------------------
module tb_nested_interval_self_time_core;
  import nist_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int RANDOM_EVENTS  = 160;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic                func;
    logic [TIME_W-1:0]   start_time;
    logic [TIME_W-1:0]   length;
    logic [TIME_W-1:0]   self_time;
    logic [IN_TAG_W-1:0] tag;
  } event_item_t;

  typedef struct packed {
    logic [OUT_TAG_W-1:0] tag;
    logic [TIME_W-1:0]    self_time;
    logic                 overflow;
    logic                 last;
  } span_result_t;

  logic                 clk_i               = 1'b0;
  logic                 rst_ni              = 1'b0;
  logic                 in_valid_i          = 1'b0;
  logic                 in_ready_o;
  logic                 func_i              = FUNC_ADD;
  logic [TIME_W-1:0]    start_time_i        = '0;
  logic [TIME_W-1:0]    length_i            = '0;
  logic [TIME_W-1:0]    initial_self_time_i = '0;
  logic [IN_TAG_W-1:0]  event_tag_i         = '0;
  logic                 out_valid_o;
  logic                 out_ready_i         = 1'b0;
  logic [OUT_TAG_W-1:0] out_tag_o;
  logic [TIME_W-1:0]    out_self_time_o;
  logic                 out_overflow_o;
  logic                 last_o;

  event_item_t  pending_events[$];
  event_item_t  cur_event;
  span_result_t exp_spans[$];
  int           errors      = 0;
  int           in_gap      = 0;
  int           out_stall   = 0;
  int           idle_cycles = 0;
  logic         in_burst    = 1'b0;
  logic         out_burst   = 1'b0;

  // Predictor copy of the open interval stack.
  logic [TIME_W-1:0]    span_start[STACK_DEPTH];
  logic [TIME_W-1:0]    span_stop[STACK_DEPTH];
  logic [TIME_W-1:0]    span_self[STACK_DEPTH];
  logic [OUT_TAG_W-1:0] span_tag[STACK_DEPTH];
  int                   span_count = 0;

  // Stimulus-side view of the open interval ends, used to build nested spans.
  logic [TIME_W-1:0] gen_open[$];
  logic [TIME_W-1:0] gen_now;

  nested_interval_self_time_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .start_time_i       (start_time_i),
    .length_i           (length_i),
    .initial_self_time_i(initial_self_time_i),
    .event_tag_i        (event_tag_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_tag_o          (out_tag_o),
    .out_self_time_o    (out_self_time_o),
    .out_overflow_o     (out_overflow_o),
    .last_o             (last_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin : reset_seq
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // End of [s, s + l), saturating at the largest time.
  function automatic logic [TIME_W-1:0] span_end(logic [TIME_W-1:0] s, logic [TIME_W-1:0] l);
    logic [TIME_W:0] sum;
    sum = {1'b0, s} + {1'b0, l};
    return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

  function automatic logic contains_span(logic [TIME_W-1:0] ps, logic [TIME_W-1:0] pe,
                                         logic [TIME_W-1:0] cs, logic [TIME_W-1:0] ce);
    return (ps <= cs) && (ce <= pe) && (cs < pe);
  endfunction

  task automatic queue_event(logic f, logic [TIME_W-1:0] s, logic [TIME_W-1:0] l,
                             logic [TIME_W-1:0] self_t, logic [IN_TAG_W-1:0] tag);
    event_item_t ev;
    ev = '{f, s, l, self_t, tag};
    pending_events.insert(pending_events.size(), ev);
  endtask

  task automatic report_mismatch(string what);
    $display("%0t: MISMATCH %s", $time, what);
    errors++;
  endtask

  function automatic void expect_span(logic [OUT_TAG_W-1:0] tag, logic [TIME_W-1:0] self_t,
                                      logic ovf);
    span_result_t r;
    r = '{tag, self_t, ovf, 1'b0};
    exp_spans.insert(exp_spans.size(), r);
  endfunction

  // Works out the intervals that one accepted item finishes.
  task automatic predict_spans(event_item_t ev);
    logic [TIME_W-1:0] ev_end;
    int                first_new;
    span_result_t      r;
    first_new = exp_spans.size();
    if (ev.func == FUNC_FLUSH) begin
      while (span_count > 0) begin
        span_count--;
        expect_span(span_tag[span_count], span_self[span_count], 1'b0);
      end
    end else begin
      ev_end = span_end(ev.start_time, ev.length);
      while (span_count > 0 &&
             !contains_span(span_start[span_count-1], span_stop[span_count-1],
                            ev.start_time, ev_end)) begin
        span_count--;
        expect_span(span_tag[span_count], span_self[span_count], 1'b0);
      end
      if (ev.length == '0) begin
        expect_span(OUT_TAG_W'(ev.tag), ev.self_time, 1'b0);
      end else begin
        if (span_count > 0)
          span_self[span_count-1] = (ev.length >= span_self[span_count-1]) ?
                                    '0 : span_self[span_count-1] - ev.length;
        if (span_count >= STACK_DEPTH) begin
          expect_span(OUT_TAG_W'(ev.tag), ev.self_time, 1'b1);
        end else begin
          span_start[span_count] = ev.start_time;
          span_stop[span_count]  = ev_end;
          span_self[span_count]  = ev.self_time;
          span_tag[span_count]   = OUT_TAG_W'(ev.tag);
          span_count++;
        end
      end
    end
    if (exp_spans.size() > first_new) begin
      r = exp_spans[$];
      r.last = 1'b1;
      exp_spans[exp_spans.size() - 1] = r;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic        busy;
    int          gap;
    event_item_t nxt;
    if (!rst_ni) begin
      in_valid_i          <= 1'b0;
      func_i              <= FUNC_ADD;
      start_time_i        <= '0;
      length_i            <= '0;
      initial_self_time_i <= '0;
      event_tag_i         <= '0;
      in_gap              <= 0;
      in_burst            <= 1'b0;
    end else begin
      busy = in_valid_i;
      gap  = in_gap;
      if (in_valid_i && in_ready_o) begin
        predict_spans(cur_event);
        busy = 1'b0;
        gap  = in_burst ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 15) == 0) in_burst <= !in_burst;
      end
      if (!busy && pending_events.size() > 0) begin
        if (gap == 0) begin
          nxt = pending_events.pop_front();
          cur_event           <= nxt;
          func_i              <= nxt.func;
          start_time_i        <= nxt.start_time;
          length_i            <= nxt.length;
          initial_self_time_i <= nxt.self_time;
          event_tag_i         <= nxt.tag;
          busy = 1'b1;
        end else begin
          gap--;
        end
      end
      in_valid_i <= busy;
      in_gap     <= gap;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    span_result_t want;
    int           st;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall   <= 0;
      out_burst   <= 1'b0;
    end else begin
      st = out_stall;
      if (out_valid_o && out_ready_i) begin
        if (exp_spans.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: tag %h self %h",
                                    out_tag_o, out_self_time_o));
        end else begin
          want = exp_spans.pop_front();
          if (out_tag_o !== want.tag)
            report_mismatch($sformatf("tag %h, want %h", out_tag_o, want.tag));
          if (out_self_time_o !== want.self_time)
            report_mismatch($sformatf("tag %h self time %h, want %h",
                                      want.tag, out_self_time_o, want.self_time));
          if (out_overflow_o !== want.overflow)
            report_mismatch($sformatf("tag %h overflow %b, want %b",
                                      want.tag, out_overflow_o, want.overflow));
          if (last_o !== want.last)
            report_mismatch($sformatf("tag %h last %b, want %b", want.tag, last_o, want.last));
        end
        st = out_burst ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 15) == 0) out_burst <= !out_burst;
      end
      if (st > 0) begin
        out_ready_i <= 1'b0;
        st--;
      end else begin
        out_ready_i <= 1'b1;
      end
      out_stall <= st;
    end
  end

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_nested_interval_self_time_core: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [TIME_W-1:0] base, s, len, room, self_v, e;
    int                pick;
    base = TIME_MAX - 64'd199;

    // A flush with nothing open gives no result.
    queue_event(FUNC_FLUSH, '0, '0, '0, '0);
    // Fill the stack with sixteen nested spans. The outer end saturates and
    // the odd levels carry a small self time so the deduction clamps at zero.
    queue_event(FUNC_ADD, base, 64'h1000, TIME_MAX, '1);
    for (int i = 1; i < STACK_DEPTH; i++)
      queue_event(FUNC_ADD, base + 64'(i), 64'(200 - 2 * i),
                  (i % 2 != 0) ? 64'd5 : 64'd1000, IN_TAG_W'(i));
    // Full stack: emitted at once with the overflow flag, still deducted.
    queue_event(FUNC_ADD, base + 64'd16, 64'd1, 64'h1234_5678_9abc_def0, 16'h00aa);
    // Instant event inside the top span.
    queue_event(FUNC_ADD, base + 64'd16, '0, 64'd77, 16'h00bb);
    // A start that goes backwards is enclosed by nothing: the whole stack
    // drains and the instant event follows it.
    queue_event(FUNC_ADD, '0, '0, '0, '0);
    // Half-open enclosure: a child starting right at the parent's end pops it.
    queue_event(FUNC_ADD, 64'd1000, 64'd10, 64'd50, 16'h0100);
    queue_event(FUNC_ADD, 64'd1010, '0, 64'd3, 16'h0101);
    // Child with the parent's start; the flush returns both, top first.
    queue_event(FUNC_ADD, 64'd2000, 64'd100, 64'd7, 16'h0200);
    queue_event(FUNC_ADD, 64'd2000, 64'd50, 64'd9, 16'h0201);
    queue_event(FUNC_FLUSH, TIME_MAX, TIME_MAX, TIME_MAX, '1);

    gen_now = 64'($urandom_range(3000, 5000));
    repeat (RANDOM_EVENTS) begin
      pick   = $urandom_range(0, 99);
      self_v = ($urandom_range(0, 1) != 0) ? rand64() : 64'($urandom_range(0, 2000));
      if (pick < 5) begin
        queue_event(FUNC_FLUSH, rand64(), rand64(), self_v, IN_TAG_W'($urandom));
        gen_open.delete();
      end else if (pick < 13) begin
        queue_event(FUNC_ADD, rand64(), rand64() >> $urandom_range(0, 63), self_v,
                    IN_TAG_W'($urandom));
        gen_open.delete();
      end else begin
        if (gen_now > TIME_MAX - 64'h1_0000_0000_0000) begin
          gen_now = 64'($urandom);
          gen_open.delete();
        end
        // Jumping to the end of an open span closes it and all spans above it.
        if (gen_open.size() > 0 && $urandom_range(0, 3) == 0)
          gen_now = gen_open[$urandom_range(0, gen_open.size() - 1)];
        while (gen_open.size() > 0 && gen_open[$] <= gen_now)
          gen_open.delete(gen_open.size() - 1);
        if (gen_open.size() == 0) begin
          s   = gen_now + 64'($urandom_range(0, 50));
          len = rand64() >> $urandom_range(1, 40);
        end else begin
          room = gen_open[$] - gen_now;
          s    = gen_now + ((rand64() % room) >> 3);
          room = gen_open[$] - s;
          len  = 64'd1 + ((rand64() % room) >> $urandom_range(0, 2));
          // Now and then a span that runs past the end of its parent.
          if ($urandom_range(0, 9) == 0) len = room + 64'($urandom_range(1, 100));
        end
        if ($urandom_range(0, 6) == 0) len = '0;
        queue_event(FUNC_ADD, s, len, self_v, IN_TAG_W'($urandom));
        gen_now = s;
        e = span_end(s, len);
        while (gen_open.size() > 0 && !(s < gen_open[$] && e <= gen_open[$]))
          gen_open.delete(gen_open.size() - 1);
        if (len != '0 && gen_open.size() < STACK_DEPTH)
          gen_open.insert(gen_open.size(), e);
      end
    end

    while (pending_events.size() > 0 || in_valid_i || exp_spans.size() > 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0)
      $display("tb_nested_interval_self_time_core: clean");
    else
      $display("tb_nested_interval_self_time_core: errors");
    $finish;
  end

endmodule
